@@ rtl/bal_pkg.sv @@
package bal_pkg;

    typedef struct packed {
        logic [15:0] code;
        logic [63:0] name;
        logic [7:0]  age;
    } rec_t;

    typedef struct packed {
        logic [3:0] command;
        logic [4:0] position;
        rec_t       rec;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        rec_t       rec;
        logic [4:0] count;
    } res_t;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADPOS   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    localparam logic [3:0] CMD_APPEND    = 4'd0;
    localparam logic [3:0] CMD_PREPEND   = 4'd1;
    localparam logic [3:0] CMD_INSERT_AT = 4'd2;
    localparam logic [3:0] CMD_POP_END   = 4'd3;
    localparam logic [3:0] CMD_POP_FRONT = 4'd4;
    localparam logic [3:0] CMD_SORTED    = 4'd5;
    localparam logic [3:0] CMD_REVERSE   = 4'd6;
    localparam logic [3:0] CMD_MAX_AGE   = 4'd7;
    localparam logic [3:0] CMD_FIND      = 4'd8;
    localparam logic [3:0] CMD_SORT_CODE = 4'd9;
    localparam logic [3:0] CMD_SORT_NAME = 4'd10;
    localparam logic [3:0] CMD_READ      = 4'd11;
    localparam logic [3:0] CMD_CLEAR     = 4'd12;

    // keep the first nb bytes, clear everything after the first zero byte
    function automatic logic [63:0] canon_name(input logic [63:0] x, input int nb);
        logic [63:0] y;
        logic        ended;
        y     = x;
        ended = 1'b0;
        for (int k = 0; k < 8; k++)
        begin
            if (k >= nb || ended)
            begin
                y[63-8*k -: 8] = 8'h00;
            end
            else if (y[63-8*k -: 8] == 8'h00)
            begin
                ended = 1'b1;
            end
        end
        return y;
    endfunction

endpackage

@@ rtl/bal_mem.sv @@
module bal_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 88
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/bal_seq.sv @@
module bal_seq #(
    parameter int DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  bal_pkg::req_t req,
    input  logic [4:0]    cap,
    output logic          res_valid,
    input  logic          res_ready,
    output bal_pkg::res_t res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RDA  = 7'b0000010,
        S_RDB  = 7'b0000100,
        S_EXEC = 7'b0001000,
        S_WRB  = 7'b0010000,
        S_INS  = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    localparam logic [2:0] M_SHUP = 3'd0;
    localparam logic [2:0] M_SCAN = 3'd1;
    localparam logic [2:0] M_GET  = 3'd2;
    localparam logic [2:0] M_POPF = 3'd3;
    localparam logic [2:0] M_MAX  = 3'd4;
    localparam logic [2:0] M_FIND = 3'd5;
    localparam logic [2:0] M_REV  = 3'd6;
    localparam logic [2:0] M_SORT = 3'd7;

    state_t        state_reg;
    logic [2:0]    mode_reg;
    logic [3:0]    cmd_reg;
    logic [CW-1:0] pos_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] a_reg;
    logic [CW-1:0] b_reg;
    logic [CW-1:0] lim_reg;
    bal_pkg::rec_t new_reg;
    bal_pkg::rec_t rec_a_reg;
    bal_pkg::rec_t out_rec_reg;
    logic [2:0]    st_reg;
    logic [7:0]    max_reg;
    logic          swap_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    bal_pkg::rec_t mem_wdata;
    bal_pkg::rec_t mem_rdata;

    logic [CW-1:0] a_inc;
    logic [CW-1:0] a_dec;
    logic [CW-1:0] cnt_dec;
    logic          full;
    logic          sw;
    logic [7:0]    max_next;
    int            limit;

    bal_mem #(.DEPTH(DEPTH), .WIDTH($bits(bal_pkg::rec_t))) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign a_inc    = a_reg + 1'b1;
    assign a_dec    = a_reg - 1'b1;
    assign cnt_dec  = cnt_reg - 1'b1;
    assign limit    = (int'(cap) > DEPTH) ? DEPTH : int'(cap);
    assign full     = int'(cnt_reg) >= limit;
    assign sw       = (cmd_reg == bal_pkg::CMD_SORT_CODE) ?
                      (rec_a_reg.code > mem_rdata.code) : (rec_a_reg.name < mem_rdata.name);
    assign max_next = (rec_a_reg.age > max_reg) ? rec_a_reg.age : max_reg;

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res.status = st_reg;
    assign res.rec    = out_rec_reg;
    assign res.count  = 5'(cnt_reg);

    assign mem_raddr = (state_reg == S_RDB) ? b_reg[AW-1:0] : a_reg[AW-1:0];

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = a_reg[AW-1:0];
        mem_wdata = rec_a_reg;
        unique case (state_reg)
            S_EXEC:
            begin
                case (mode_reg)
                    M_SHUP:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = a_inc[AW-1:0];
                    end
                    M_POPF:
                    begin
                        mem_we    = (a_reg != '0);
                        mem_waddr = a_dec[AW-1:0];
                    end
                    M_REV:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = mem_rdata;
                    end
                    M_SORT:
                    begin
                        mem_we    = sw;
                        mem_wdata = mem_rdata;
                    end
                    default:
                    begin
                        mem_we = 1'b0;
                    end
                endcase
            end
            S_WRB:
            begin
                mem_we    = swap_reg;
                mem_waddr = b_reg[AW-1:0];
            end
            S_INS:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg[AW-1:0];
                mem_wdata = new_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        cmd_reg     <= req.command;
                        new_reg     <= req.rec;
                        pos_reg     <= CW'(req.position);
                        st_reg      <= bal_pkg::ST_OK;
                        out_rec_reg <= '0;
                        max_reg     <= '0;
                        swap_reg    <= 1'b0;
                        a_reg       <= '0;
                        b_reg       <= CW'(1);
                        lim_reg     <= cnt_reg;
                        state_reg   <= S_DONE;
                        case (req.command) inside
                            bal_pkg::CMD_APPEND, bal_pkg::CMD_PREPEND,
                            bal_pkg::CMD_INSERT_AT, bal_pkg::CMD_SORTED:
                            begin
                                if (req.command == bal_pkg::CMD_INSERT_AT &&
                                    int'(req.position) > int'(cnt_reg))
                                begin
                                    st_reg <= bal_pkg::ST_BADPOS;
                                end
                                else if (full)
                                begin
                                    st_reg <= bal_pkg::ST_FULL;
                                end
                                else if (req.command == bal_pkg::CMD_APPEND || cnt_reg == '0)
                                begin
                                    pos_reg   <= (req.command == bal_pkg::CMD_INSERT_AT) ?
                                                 CW'(req.position) : cnt_reg;
                                    if (req.command == bal_pkg::CMD_PREPEND)
                                    begin
                                        pos_reg <= '0;
                                    end
                                    state_reg <= S_INS;
                                end
                                else if (req.command == bal_pkg::CMD_SORTED)
                                begin
                                    pos_reg   <= cnt_reg;
                                    mode_reg  <= M_SCAN;
                                    state_reg <= S_RDA;
                                end
                                else if (req.command == bal_pkg::CMD_INSERT_AT &&
                                         int'(req.position) == int'(cnt_reg))
                                begin
                                    state_reg <= S_INS;
                                end
                                else
                                begin
                                    if (req.command == bal_pkg::CMD_PREPEND)
                                    begin
                                        pos_reg <= '0;
                                    end
                                    a_reg     <= cnt_dec;
                                    mode_reg  <= M_SHUP;
                                    state_reg <= S_RDA;
                                end
                            end
                            bal_pkg::CMD_POP_END:
                            begin
                                if (cnt_reg == '0)
                                begin
                                    st_reg <= bal_pkg::ST_EMPTY;
                                end
                                else
                                begin
                                    a_reg     <= cnt_dec;
                                    cnt_reg   <= cnt_dec;
                                    mode_reg  <= M_GET;
                                    state_reg <= S_RDA;
                                end
                            end
                            bal_pkg::CMD_POP_FRONT, bal_pkg::CMD_MAX_AGE:
                            begin
                                if (cnt_reg == '0)
                                begin
                                    st_reg <= bal_pkg::ST_EMPTY;
                                end
                                else
                                begin
                                    mode_reg  <= (req.command == bal_pkg::CMD_MAX_AGE) ?
                                                 M_MAX : M_POPF;
                                    state_reg <= S_RDA;
                                end
                            end
                            bal_pkg::CMD_FIND:
                            begin
                                if (cnt_reg == '0)
                                begin
                                    st_reg <= bal_pkg::ST_NOTFOUND;
                                end
                                else
                                begin
                                    mode_reg  <= M_FIND;
                                    state_reg <= S_RDA;
                                end
                            end
                            bal_pkg::CMD_REVERSE:
                            begin
                                if (int'(cnt_reg) >= 2)
                                begin
                                    b_reg     <= cnt_dec;
                                    mode_reg  <= M_REV;
                                    state_reg <= S_RDA;
                                end
                            end
                            bal_pkg::CMD_SORT_CODE, bal_pkg::CMD_SORT_NAME:
                            begin
                                if (int'(cnt_reg) >= 2)
                                begin
                                    mode_reg  <= M_SORT;
                                    state_reg <= S_RDA;
                                end
                            end
                            bal_pkg::CMD_READ:
                            begin
                                if (int'(req.position) >= int'(cnt_reg))
                                begin
                                    st_reg <= bal_pkg::ST_BADPOS;
                                end
                                else
                                begin
                                    a_reg     <= CW'(req.position);
                                    mode_reg  <= M_GET;
                                    state_reg <= S_RDA;
                                end
                            end
                            bal_pkg::CMD_CLEAR:
                            begin
                                cnt_reg <= '0;
                            end
                            default:
                            begin
                                st_reg <= bal_pkg::ST_OK;
                            end
                        endcase
                    end
                end
                S_RDA:
                begin
                    state_reg <= S_RDB;
                end
                S_RDB:
                begin
                    rec_a_reg <= mem_rdata;
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    state_reg <= S_RDA;
                    case (mode_reg)
                        M_SHUP:
                        begin
                            if (a_reg == pos_reg)
                            begin
                                state_reg <= S_INS;
                            end
                            else
                            begin
                                a_reg <= a_dec;
                            end
                        end
                        M_SCAN:
                        begin
                            if (new_reg.code < rec_a_reg.code)
                            begin
                                pos_reg  <= a_reg;
                                a_reg    <= cnt_dec;
                                mode_reg <= M_SHUP;
                            end
                            else if (a_inc == cnt_reg)
                            begin
                                state_reg <= S_INS;
                            end
                            else
                            begin
                                a_reg <= a_inc;
                            end
                        end
                        M_GET:
                        begin
                            out_rec_reg <= rec_a_reg;
                            state_reg   <= S_DONE;
                        end
                        M_POPF:
                        begin
                            if (a_reg == '0)
                            begin
                                out_rec_reg <= rec_a_reg;
                            end
                            if (a_inc == cnt_reg)
                            begin
                                cnt_reg   <= cnt_dec;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                a_reg <= a_inc;
                            end
                        end
                        M_MAX:
                        begin
                            max_reg <= max_next;
                            if (a_inc == cnt_reg)
                            begin
                                out_rec_reg.age <= max_next;
                                state_reg       <= S_DONE;
                            end
                            else
                            begin
                                a_reg <= a_inc;
                            end
                        end
                        M_FIND:
                        begin
                            if (rec_a_reg.name == new_reg.name)
                            begin
                                out_rec_reg <= rec_a_reg;
                                state_reg   <= S_DONE;
                            end
                            else if (a_inc == cnt_reg)
                            begin
                                st_reg    <= bal_pkg::ST_NOTFOUND;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                a_reg <= a_inc;
                            end
                        end
                        M_REV:
                        begin
                            swap_reg  <= 1'b1;
                            state_reg <= S_WRB;
                        end
                        default:
                        begin
                            swap_reg  <= sw;
                            state_reg <= S_WRB;
                        end
                    endcase
                end
                S_WRB:
                begin
                    state_reg <= S_RDA;
                    if (mode_reg == M_REV)
                    begin
                        if (int'(a_reg) + 2 < int'(b_reg))
                        begin
                            a_reg <= a_inc;
                            b_reg <= b_reg - 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                    else if (int'(b_reg) + 1 < int'(lim_reg))
                    begin
                        a_reg <= a_inc;
                        b_reg <= b_reg + 1'b1;
                    end
                    else if (int'(lim_reg) > 2)
                    begin
                        lim_reg <= lim_reg - 1'b1;
                        a_reg   <= '0;
                        b_reg   <= CW'(1);
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_INS:
                begin
                    cnt_reg   <= cnt_reg + 1'b1;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(cnt_reg) <= DEPTH)
        else $error("record count above depth");

    a_ins_inc: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INS |=> cnt_reg == CW'($past(cnt_reg) + 1'b1))
        else $error("insert did not bump count");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_EXEC || state_reg == S_WRB || state_reg == S_INS))
        else $error("memory write outside write states");

endmodule

@@ rtl/bounded_array_list_engine.sv @@
// Bounded array list engine: keeps an ordered list of up to DEPTH records
// (code, name, age) in a single-port-read, single-port-write memory and runs
// one request at a time, returning one response per request. Its run time is
// set by the memory read loop: each entry shifted or scanned passes through
// the states S_RDA, S_RDB and S_EXEC, and each compare-swap also through
// S_WRB. A new request is taken while the previous response still waits in
// the output register.
module bounded_array_list_engine #(
    parameter int DEPTH      = 16,
    parameter int NAME_BYTES = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[3:0], position[8:4], entry_code[24:9], entry_name[88:25],
    // entry_age[96:89], zero fill[103:97]
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], out_code[18:3], out_name[82:19], out_age[90:83], out_count[95:91]
    output logic [95:0]  m_tdata,
    input  logic         cfg_we,
    input  logic [4:0]   cfg_wdata
);

    logic [4:0]    capacity_reg;
    logic          m_tvalid_reg;
    logic [95:0]   m_tdata_reg;
    bal_pkg::req_t req;
    bal_pkg::res_t res;
    logic          res_valid;
    logic          res_ready;

    assign req.command  = s_tdata[3:0];
    assign req.position = s_tdata[8:4];
    assign req.rec.code = s_tdata[24:9];
    assign req.rec.name = bal_pkg::canon_name(s_tdata[88:25], NAME_BYTES);
    assign req.rec.age  = s_tdata[96:89];

    assign res_ready = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    bal_seq #(.DEPTH(DEPTH)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .cap       (capacity_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= 5'd16;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (res_valid && res_ready)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_tdata_reg <= {res.count, res.rec.age, res.rec.name, res.rec.code, res.status};
        end
    end

endmodule
